// ===== src/mplc_pkg.sv =====
// ----------------------------------------------------------------------------
// mplc_pkg: shared types and constants of the Markov packet-loss channel
// Field widths, operation codes and controller/datapath command structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mplc_pkg;

  localparam int MAX_STATES = 8;
  localparam int IDX_W      = 3;                  // state index width
  localparam int MEM_DEPTH  = MAX_STATES * MAX_STATES;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int PROB_BITS  = 16;
  localparam int PROB_W     = PROB_BITS + 1;      // fraction plus the 1.0 bit
  localparam int RAND_W     = PROB_BITS;
  localparam int SUM_W      = PROB_W + IDX_W;     // holds MAX_STATES entries of 1.0
  localparam int OP_W       = 2;
  localparam int CFG_W      = 4;

  localparam logic [PROB_W-1:0] PROB_ONE      = PROB_W'(1) << PROB_BITS;
  localparam logic [CFG_W-1:0]  STATES_RESET  = CFG_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_PACKET   = 2'd0,
    OP_WR_DROP  = 2'd1,
    OP_WR_TRANS = 2'd2
  } op_t;

  typedef struct packed {
    logic start;        // capture a packet and clear the walk
    logic write_drop;   // write one drop-table entry
    logic write_trans;  // write one transition-table entry
    logic walk;         // accumulate one row entry
    logic finish;       // commit the new state and load the result
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } status_t;

endpackage

`default_nettype wire

// ===== src/mplc_item_if.sv =====
// ----------------------------------------------------------------------------
// mplc_item_if: request channel of the Markov packet-loss channel
// Valid/ready channel carrying packet and table-load requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface mplc_item_if;
  import mplc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [IDX_W-1:0]    row_index;
  logic [IDX_W-1:0]    column_index;
  logic [PROB_W-1:0]   probability;
  logic [RAND_W-1:0]   rand_step;
  logic [RAND_W-1:0]   rand_drop;

  modport source (
    output valid, op, row_index, column_index, probability, rand_step, rand_drop,
    input  ready
  );

  modport sink (
    input  valid, op, row_index, column_index, probability, rand_step, rand_drop,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/mplc_result_if.sv =====
// ----------------------------------------------------------------------------
// mplc_result_if: result channel of the Markov packet-loss channel
// Valid/ready channel carrying the drop decision and the new state.
// ----------------------------------------------------------------------------
`default_nettype none

interface mplc_result_if;
  import mplc_pkg::*;

  logic             valid;
  logic             ready;
  logic             dropped;
  logic [IDX_W-1:0] new_state;

  modport source (
    output valid, dropped, new_state,
    input  ready
  );

  modport sink (
    input  valid, dropped, new_state,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/mplc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mplc_ctrl: controller of the Markov packet-loss channel
// Sequences request intake, the row walk and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module mplc_ctrl
  import mplc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  input  wire logic [OP_W-1:0] item_op,
  output logic                 item_ready,
  input  wire logic            result_ready,
  output logic                 result_valid,
  output cmd_t                 cmd,
  input  wire status_t         status
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(item_op))
            OP_PACKET: begin
              cmd.start  = 1'b1;
              state_next = S_WALK;
            end
            OP_WR_DROP:  cmd.write_drop  = 1'b1;
            OP_WR_TRANS: cmd.write_trans = 1'b1;
            default: ;  // drop unknown requests
          endcase
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish)        result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/mplc_dpath.sv =====
// ----------------------------------------------------------------------------
// mplc_dpath: datapath of the Markov packet-loss channel
// Probability tables, running-sum walk, state register and result payload.
// ----------------------------------------------------------------------------
`default_nettype none

module mplc_dpath
  import mplc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_W-1:0]  cfg_wr_data,
  input  wire logic [IDX_W-1:0]  row_index,
  input  wire logic [IDX_W-1:0]  column_index,
  input  wire logic [PROB_W-1:0] probability,
  input  wire logic [RAND_W-1:0] rand_step,
  input  wire logic [RAND_W-1:0] rand_drop,
  input  wire cmd_t              cmd,
  output status_t                status,
  output logic                   dropped,
  output logic [IDX_W-1:0]       new_state
);

  logic [CFG_W-1:0]  states_in_use;
  logic [IDX_W-1:0]  current_state;
  logic [IDX_W-1:0]  last_state;
  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  col_inc;
  logic [IDX_W-1:0]  pick;
  logic [IDX_W-1:0]  next_q;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_new;
  logic [RAND_W-1:0] rstep_q;
  logic [RAND_W-1:0] rdrop_q;
  logic [PROB_W-1:0] prob_clamped;
  logic [PROB_W-1:0] rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic              hit;
  logic              at_last;

  logic [PROB_W-1:0] trans_mem [MEM_DEPTH];
  logic [PROB_W-1:0] drop_table [MAX_STATES];

  // Out-of-range state counts act as the nearest legal count.
  always_comb begin
    if (states_in_use == '0)                      last_state = '0;
    else if (states_in_use > CFG_W'(MAX_STATES)) last_state = IDX_W'(MAX_STATES - 1);
    else                                          last_state = IDX_W'(states_in_use - CFG_W'(1));
  end

  assign prob_clamped = (probability > PROB_ONE) ? PROB_ONE : probability;

  assign col_inc = col + IDX_W'(1);
  assign sum_new = sum + SUM_W'(rdata);
  assign hit     = (sum_new >= SUM_W'(rstep_q));
  assign at_last = (col == last_state);
  assign pick    = hit ? col : last_state;
  assign status.walk_done = hit || at_last;

  // Prefetch column 0 while idle, the following column while walking.
  assign rd_addr = cmd.walk ? {current_state, col_inc} : {current_state, {IDX_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (cmd.write_trans) trans_mem[{row_index, column_index}] <= prob_clamped;
    else                 rdata <= trans_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.write_drop) drop_table[row_index] <= prob_clamped;
  end

  always_ff @(posedge clk) begin
    if (rst) states_in_use <= STATES_RESET;
    else if (cfg_wr_en) states_in_use <= cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) current_state <= '0;
    else if (cmd.finish) current_state <= next_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      col     <= '0;
      sum     <= '0;
      rstep_q <= rand_step;
      rdrop_q <= rand_drop;
    end else if (cmd.walk) begin
      if (status.walk_done) begin
        next_q <= pick;
      end else begin
        col <= col_inc;
        sum <= sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dropped   <= ({1'b0, rdrop_q} < drop_table[next_q]);
      new_state <= next_q;
    end
  end

endmodule

`default_nettype wire

// ===== src/markov_packet_loss_channel.sv =====
// ----------------------------------------------------------------------------
// markov_packet_loss_channel: N-state Markov packet-loss channel
// Gilbert-Elliott style loss channel with loadable probability tables.
// ----------------------------------------------------------------------------
// Usage:
//   item    - request channel (valid/ready). op selects a packet, a drop-table
//             write or a transition-table write; unknown ops are dropped.
//   result  - one result per packet request: dropped flag and new state.
//             Table writes produce no result.
//   cfg_wr_en / cfg_wr_data - states_in_use register; write only while idle.
// Timing:
//   Table writes can be issued back to back. A packet reads its current row
//   out of a one-port transition memory, one column per cycle, until the
//   running sum reaches rand_step or the last column in use is read. No new
//   request is taken while the packet walks or waits to load its result.
// Reset (rst, synchronous): current state 0, states_in_use 2, no result
//   pending. Tables hold no reset value and must be loaded before use.
// Stall: the result sits in an output register; while it waits, the block
//   still takes writes and one more packet, which then holds its finished
//   result until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module markov_packet_loss_channel
  import mplc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  mplc_item_if.sink             item,
  mplc_result_if.source         result,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  cmd_t    cmd;
  status_t status;

  // Controller: intake, walk sequencing and result handoff.
  mplc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_op      (item.op),
    .item_ready   (item.ready),
    .result_ready (result.ready),
    .result_valid (result.valid),
    .cmd          (cmd),
    .status       (status)
  );

  // Datapath: tables, running sum, channel state and result payload.
  mplc_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .row_index    (item.row_index),
    .column_index (item.column_index),
    .probability  (item.probability),
    .rand_step    (item.rand_step),
    .rand_drop    (item.rand_drop),
    .cmd          (cmd),
    .status       (status),
    .dropped      (result.dropped),
    .new_state    (result.new_state)
  );

endmodule

`default_nettype wire

// ===== src/mplc_checker.sv =====
// ----------------------------------------------------------------------------
// mplc_checker: port checks of the Markov packet-loss channel
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mplc_checker
  import mplc_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_ready,
  input wire logic [OP_W-1:0]  item_op,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire logic             result_dropped,
  input wire logic [IDX_W-1:0] result_new_state
);

  // A stalled result stays offered.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // A packet request occupies the block for its walk.
  a_packet_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_op == OP_PACKET |=> !item_ready)
    else $error("request taken during a walk");

  // Table writes and unknown ops never stall the request channel.
  a_write_ready: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_op != OP_PACKET |=> item_ready)
    else $error("request channel stalled after a table write");

  // A stalled result keeps its payload.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result_dropped) && $stable(result_new_state))
    else $error("result payload changed while stalled");

endmodule

bind markov_packet_loss_channel mplc_checker u_mplc_checker (
  .clk              (clk),
  .rst              (rst),
  .item_valid       (item.valid),
  .item_ready       (item.ready),
  .item_op          (item.op),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_dropped   (result.dropped),
  .result_new_state (result.new_state)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Markov packet-loss channel
// Loads the drop and transition tables, sends packet requests through the
// valid/ready channel and checks every drop decision and next state against
// a cycle-free predictor kept in step at each accepted request.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import mplc_pkg::*;

  // Op code 3 has no meaning in the block; it must be swallowed silently.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT     = 600_000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RESET_CYCLES    = 12;

  typedef struct packed {
    logic             dropped;
    logic [IDX_W-1:0] new_state;
  } verdict_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  mplc_item_if   item_ch ();
  mplc_result_if result_ch ();

  markov_packet_loss_channel uut (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Traffic shaping knobs, set by the test tasks.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_len;
  int hold_off_seq;
  int error_count;
  int cycle_count;

  // Predictor copy of the channel: state, register and both tables.
  logic [CFG_W-1:0]  model_states_cfg;
  logic [IDX_W-1:0]  model_state;
  logic [PROB_W-1:0] drop_prob  [MAX_STATES];
  logic [PROB_W-1:0] trans_prob [MAX_STATES][MAX_STATES];
  verdict_t          pending_verdicts [$];

  // --------------------------------------------------------------------------
  // Clock and timeout
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run: count cycles and give up well past the slowest pass.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Table writes saturate anything above 1.0.
  function automatic logic [PROB_W-1:0] clamp_prob(input logic [PROB_W-1:0] p);
    return (p > PROB_ONE) ? PROB_ONE : p;
  endfunction

  // Advance the predictor by the request currently accepted on item_ch.
  function automatic void apply_request();
    int unsigned      active;
    int unsigned      sum;
    int unsigned      col;
    logic [IDX_W-1:0] nxt;
    verdict_t         v;
    case (item_ch.op)
      OP_WR_DROP:  drop_prob[item_ch.row_index] = clamp_prob(item_ch.probability);
      OP_WR_TRANS: trans_prob[item_ch.row_index][item_ch.column_index] =
                     clamp_prob(item_ch.probability);
      OP_PACKET: begin
        // Clamp the register into 1..MAX_STATES.
        if (model_states_cfg == '0) begin
          active = 1;
        end else if (model_states_cfg > MAX_STATES) begin
          active = MAX_STATES;
        end else begin
          active = 32'(model_states_cfg);
        end
        // Walk the current row; fall back to the last state in use.
        nxt = IDX_W'(active - 1);
        sum = 0;
        for (col = 0; col < active; col++) begin
          sum += trans_prob[model_state][col];
          if (sum >= item_ch.rand_step) begin
            nxt = IDX_W'(col);
            break;
          end
        end
        model_state = nxt;
        v.new_state = nxt;
        v.dropped   = (item_ch.rand_drop < drop_prob[nxt]);
        pending_verdicts.push_back(v);
      end
      default: ;  // unknown op: no effect, no result
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample both channels and the register port at each rising edge.
  // Check the outgoing result before predicting a new one, since a result
  // can never belong to the request accepted on the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    verdict_t want;
    if (rst) begin
      model_state      = '0;
      model_states_cfg = STATES_RESET;
      pending_verdicts.delete();
    end else begin
      if (cfg_wr_en) begin
        model_states_cfg = cfg_wr_data;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, got dropped %0b new_state %0d",
                   $time, result_ch.dropped, result_ch.new_state);
        end else begin
          want = pending_verdicts.pop_front();
          if (result_ch.dropped !== want.dropped) begin
            error_count++;
            $display("%0t: dropped mismatch, expected %0b, got %0b",
                     $time, want.dropped, result_ch.dropped);
          end
          if (result_ch.new_state !== want.new_state) begin
            error_count++;
            $display("%0t: new_state mismatch, expected %0d, got %0d",
                     $time, want.new_state, result_ch.new_state);
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        apply_request();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall at random, or hold off for a counted stretch whenever a
  // test bumps hold_off_seq.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int seen_seq;
    hold_left = 0;
    seen_seq  = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_seq != seen_seq) begin
        seen_seq  = hold_off_seq;
        hold_left = hold_off_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. All of them start and end on a rising edge. Valid stays
  // high after a handshake so that back-to-back requests never drop it; the
  // next call lowers it only when it decides to idle.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [OP_W-1:0]   op,
                              input logic [IDX_W-1:0]  row,
                              input logic [IDX_W-1:0]  col,
                              input logic [PROB_W-1:0] prob,
                              input logic [RAND_W-1:0] step,
                              input logic [RAND_W-1:0] drop);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.op           <= op;
    item_ch.row_index    <= row;
    item_ch.column_index <= col;
    item_ch.probability  <= prob;
    item_ch.rand_step    <= step;
    item_ch.rand_drop    <= drop;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Fill the unused fields of each request with noise.
  task automatic send_packet(input logic [RAND_W-1:0] step,
                             input logic [RAND_W-1:0] drop);
    send_request(OP_PACKET, IDX_W'($urandom), IDX_W'($urandom),
                 PROB_W'($urandom), step, drop);
  endtask

  task automatic load_drop(input logic [IDX_W-1:0] row, input logic [PROB_W-1:0] prob);
    send_request(OP_WR_DROP, row, IDX_W'($urandom), prob,
                 RAND_W'($urandom), RAND_W'($urandom));
  endtask

  task automatic load_trans(input logic [IDX_W-1:0]  row,
                            input logic [IDX_W-1:0]  col,
                            input logic [PROB_W-1:0] prob);
    send_request(OP_WR_TRANS, row, col, prob, RAND_W'($urandom), RAND_W'($urandom));
  endtask

  // Fill every table entry; transition entries go up to row_cap so that row
  // sums land both above and below 1.0.
  task automatic load_tables(input int unsigned row_cap);
    int r;
    int c;
    for (r = 0; r < MAX_STATES; r++) begin
      load_drop(IDX_W'(r), PROB_W'($urandom_range(0, PROB_ONE)));
      for (c = 0; c < MAX_STATES; c++) begin
        load_trans(IDX_W'(r), IDX_W'(c), PROB_W'($urandom_range(0, row_cap)));
      end
    end
  endtask

  // Pause the sender until every expected result is back, then let any
  // table write still in flight settle.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the register; call only while the block is idle.
  task automatic write_states_in_use(input logic [CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Load every entry before any packet reads one.
  task automatic test_table_load();
    load_tables(16384);
  endtask

  // Hand-built rows over two states (reset register value).
  task automatic test_directed_cases();
    load_trans(3'd0, 3'd0, '0);
    load_trans(3'd0, 3'd1, PROB_ONE);
    load_trans(3'd1, 3'd0, PROB_ONE);
    load_trans(3'd1, 3'd1, '0);
    load_drop(3'd0, '0);
    load_drop(3'd1, PROB_ONE);
    send_packet('0, '0);                    // zero step: stay in state 0, keep
    send_packet(16'hFFFF, 16'hFFFF);        // move to state 1, certain drop
    send_packet(16'd1, '0);                 // back to state 0
    load_trans(3'd0, 3'd0, 17'h1FFFF);      // saturate to 1.0
    send_packet(16'hFFFF, 16'hFFFF);        // first column covers it
    load_trans(3'd0, 3'd0, '0);
    load_trans(3'd0, 3'd1, '0);
    load_drop(3'd1, 17'h10001);             // saturate to 1.0
    send_packet(16'd1, 16'hFFFF);           // no column reaches: last state
    send_request(OP_UNUSED, 3'd7, 3'd7, 17'h1FFFF, 16'hFFFF, 16'hFFFF);
    load_trans(3'd1, 3'd0, 17'h8000);
    load_trans(3'd1, 3'd1, 17'h8000);
    send_packet(16'h8000, 16'h7FFF);        // running sum meets step exactly
    send_packet(16'h8001, '0);
    drain_results();
  endtask

  // Sweep the register over its extremes, including a shrink below the
  // current state.
  task automatic test_states_in_use();
    logic [IDX_W-1:0] here;
    int c;
    write_states_in_use(4'd8);
    repeat (16) send_packet(RAND_W'($urandom), RAND_W'($urandom));
    drain_results();
    // Steer the channel into the top state.
    here = model_state;
    for (c = 0; c < MAX_STATES; c++) begin
      load_trans(here, IDX_W'(c), (c == MAX_STATES - 1) ? PROB_ONE : '0);
    end
    send_packet(16'hFFFF, RAND_W'($urandom));
    drain_results();
    // Shrink to two states while sitting in state 7.
    write_states_in_use(4'd2);
    repeat (6) send_packet(RAND_W'($urandom), RAND_W'($urandom));
    drain_results();
    write_states_in_use(4'd0);              // acts as one state
    repeat (6) send_packet(RAND_W'($urandom), RAND_W'($urandom));
    drain_results();
    write_states_in_use(4'd15);             // acts as all states
    repeat (10) send_packet(RAND_W'($urandom), RAND_W'($urandom));
    drain_results();
    write_states_in_use(4'd1);
    repeat (6) send_packet(RAND_W'($urandom), RAND_W'($urandom));
    drain_results();
  endtask

  // Hold the result side off while packets keep coming, so the output
  // register and the second packet slot fill and the input stalls.
  task automatic test_back_pressure();
    write_states_in_use(4'd8);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_len   = HOLD_OFF_CYCLES;
    hold_off_seq++;
    repeat (24) send_packet(RAND_W'($urandom), RAND_W'($urandom));
    drain_results();
  endtask

  // Mostly packets, with table rewrites and unknown ops mixed in.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [CFG_W-1:0] states, input int count);
    int n;
    int pick;
    logic [RAND_W-1:0] step;
    logic [PROB_W-1:0] prob;
    drain_results();
    write_states_in_use(states);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    load_tables($urandom_range(4096, PROB_ONE));
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      prob = ($urandom_range(3) == 0) ? PROB_W'($urandom) : PROB_W'($urandom_range(0, 20000));
      if (pick < 84) begin
        // Bias some steps low so that early columns win too.
        step = ($urandom_range(3) == 0) ? RAND_W'($urandom_range(0, 255)) : RAND_W'($urandom);
        send_packet(step, RAND_W'($urandom));
      end else if (pick < 90) begin
        load_drop(IDX_W'($urandom), prob);
      end else if (pick < 96) begin
        load_trans(IDX_W'($urandom), IDX_W'($urandom), prob);
      end else begin
        send_request(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), PROB_W'($urandom),
                     RAND_W'($urandom), RAND_W'($urandom));
      end
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_len   = 0;
    hold_off_seq   = 0;
    // Drive every input to a known value from time zero.
    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    item_ch.valid        <= 1'b0;
    item_ch.op           <= OP_PACKET;
    item_ch.row_index    <= '0;
    item_ch.column_index <= '0;
    item_ch.probability  <= '0;
    item_ch.rand_step    <= '0;
    item_ch.rand_drop    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_table_load();
    test_directed_cases();
    test_states_in_use();
    test_back_pressure();
    test_random_traffic(0, 0, 4'd8, 300);
    test_random_traffic(74, 0, 4'd3, 300);
    test_random_traffic(0, 74, 4'd15, 300);
    test_random_traffic(21, 21, 4'd5, 300);

    // drain_results only returns once no expectation is left.
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
